// File: rtl/ccor_pkg.sv
// shared types, constants and fixed-point helpers for the cell-cycle ode rhs block
// no dependencies; used by every module in rtl
`default_nettype none
package ccor_pkg;

    localparam int DIV_QBITS  = 48;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = DIV_QBITS / DIV_STEP;
    // setup stage + iteration stages + sign/saturate stage
    localparam int DIV_LAT    = DIV_STAGES + 2;

    localparam logic signed [31:0] Q_ONE    = 32'sd65536;
    localparam logic signed [31:0] Q_SIXTY  = 32'sd3932160;
    localparam logic signed [31:0] Q_TEN    = 32'sd655360;
    localparam logic signed [31:0] Q_B4     = 32'sd360448;
    localparam logic signed [31:0] Q_QUART  = 32'sd16384;
    localparam logic signed [31:0] Q_TENTH  = 32'sd6554;
    localparam logic signed [31:0] Q_FOUR_C = 32'sd2621;
    localparam logic signed [31:0] Q_ONE_C  = 32'sd655;
    localparam logic signed [31:0] Q_ONE_FOUR_C = 32'sd68157;
    // reciprocal of ten, exact with a 35 bit shift for any 32 bit operand
    localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_A1   = 2'd1;
    localparam logic [1:0] CFG_C1   = 2'd2;

    typedef struct packed {
        logic signed [31:0] apc_level;
        logic signed [31:0] cyclin_level;
        logic signed [31:0] p27_level;
        logic signed [31:0] cell_mass;
        logic signed [31:0] rbnp_level;
        logic signed [31:0] oxygen_level;
    } in_t;

    typedef struct packed {
        logic signed [31:0] apc_rate;
        logic signed [31:0] cyclin_rate;
        logic signed [31:0] p27_rate;
        logic signed [31:0] mass_rate;
        logic signed [31:0] rbnp_rate;
        logic               range_fault;
    } out_t;

    typedef struct packed {
        logic        cancer_mode;
        logic [16:0] cyclin_decay_rate;
        logic [16:0] p27_production_rate;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               flt;
    } qres_t;

    typedef struct packed {
        logic [31:0]          rem;
        logic [DIV_QBITS-1:0] num;
        logic [DIV_QBITS-1:0] quo;
        logic [31:0]          den;
        logic                 neg;
        logic                 zero;
    } div_state_t;

    function automatic qres_t q_sat(input logic signed [63:0] v);
        qres_t r;
        if (v > 64'sd2147483647)
        begin
            r.val = 32'sh7FFFFFFF;
            r.flt = 1'b1;
        end
        else if (v < -64'sd2147483648)
        begin
            r.val = 32'sh80000000;
            r.flt = 1'b1;
        end
        else
        begin
            r.val = v[31:0];
            r.flt = 1'b0;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sext(input logic signed [31:0] a);
        return {{32{a[31]}}, a};
    endfunction

    function automatic qres_t q_add(input logic signed [31:0] a, input logic signed [31:0] b);
        return q_sat(sext(a) + sext(b));
    endfunction

    function automatic qres_t q_sub(input logic signed [31:0] a, input logic signed [31:0] b);
        return q_sat(sext(a) - sext(b));
    endfunction

    // round to nearest, ties up, via floor of (p + half)
    function automatic qres_t q_mul(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [63:0] p;
        p = sext(a) * sext(b);
        p = p + 64'sd32768;
        return q_sat(p >>> 16);
    endfunction

    function automatic div_state_t div_step(input div_state_t s);
        div_state_t r;
        logic [32:0] trial;
        r = s;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial = {r.rem, r.num[DIV_QBITS-1]};
            r.num = {r.num[DIV_QBITS-2:0], 1'b0};
            if (trial >= {1'b0, r.den})
            begin
                trial = trial - {1'b0, r.den};
                r.quo = {r.quo[DIV_QBITS-2:0], 1'b1};
            end
            else
            begin
                r.quo = {r.quo[DIV_QBITS-2:0], 1'b0};
            end
            r.rem = trial[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ccor_cfg.sv
// configuration registers: mode and the two rates
// depends on ccor_pkg
`default_nettype none
module ccor_cfg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [16:0]      cfg_data,
    output ccor_pkg::cfg_t        cfg
);
    import ccor_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cancer_mode         <= 1'b0;
            cfg_reg.cyclin_decay_rate   <= 17'd3277;
            cfg_reg.p27_production_rate <= 17'd6554;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE: cfg_reg.cancer_mode         <= cfg_data[0];
                CFG_A1:   cfg_reg.cyclin_decay_rate   <= cfg_data;
                CFG_C1:   cfg_reg.p27_production_rate <= cfg_data;
                default:  ;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/ccor_div.sv
// pipelined rounding q16.16 divider, DIV_STEP quotient bits per stage
// depends on ccor_pkg
`default_nettype none
module ccor_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic                    out_valid,
    output ccor_pkg::qres_t         quo
);
    import ccor_pkg::*;

    div_state_t st_reg [0:DIV_STAGES];
    logic       vld_reg [0:DIV_STAGES];
    div_state_t setup_next;
    qres_t      quo_reg;
    qres_t      quo_next;
    logic       out_valid_reg;
    logic [31:0] na;
    logic [31:0] nb;
    logic [DIV_QBITS-1:0] q;

    always_comb
    begin
        na = num[31] ? (~num + 32'd1) : num;
        nb = den[31] ? (~den + 32'd1) : den;
        setup_next.rem  = '0;
        setup_next.num  = {na, 16'b0} + {{(DIV_QBITS-31){1'b0}}, nb[31:1]};
        setup_next.quo  = '0;
        setup_next.den  = nb;
        setup_next.neg  = num[31] != den[31];
        setup_next.zero = den == 32'sd0;
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= setup_next;
    end

    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            st_reg[k] <= div_step(st_reg[k-1]);
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0]    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0]    <= in_valid;
            out_valid_reg <= vld_reg[DIV_STAGES];
        end
    end

    // sign, saturation and divide-by-zero fault of the finished magnitude
    always_comb
    begin
        q = st_reg[DIV_STAGES].quo;
        if (st_reg[DIV_STAGES].zero)
        begin
            quo_next.val = '0;
            quo_next.flt = 1'b1;
        end
        else if (st_reg[DIV_STAGES].neg)
        begin
            if (q > {{(DIV_QBITS-32){1'b0}}, 32'h80000000})
            begin
                quo_next.val = 32'sh80000000;
                quo_next.flt = 1'b1;
            end
            else
            begin
                quo_next.val = ~q[31:0] + 32'd1;
                quo_next.flt = 1'b0;
            end
        end
        else if (q > {{(DIV_QBITS-32){1'b0}}, 32'h7FFFFFFF})
        begin
            quo_next.val = 32'sh7FFFFFFF;
            quo_next.flt = 1'b1;
        end
        else
        begin
            quo_next.val = q[31:0];
            quo_next.flt = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign out_valid = out_valid_reg;
    assign quo       = quo_reg;

endmodule
`default_nettype wire

// File: rtl/cell_cycle_ode_rhs_top.sv
// top level of the cell-cycle ode right-hand side pipeline
// depends on ccor_pkg, ccor_cfg, ccor_div
//
//  channel   handshake              payload
//  input     start / busy           in_item  (ccor_pkg::in_t)
//  result    done strobe            result   (ccor_pkg::out_t)
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item enters per cycle; busy is always low
// the path runs through the three 48 bit dividers at 2 bits a stage
// the five stages around the dividers hold the 32x32 multiplies and adds, each with its saturation
// reset clears the valid bits and loads the register defaults
// nothing stalls: every stage advances each cycle
`default_nettype none
module cell_cycle_ode_rhs_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire ccor_pkg::in_t in_item,
    output logic              done,
    output ccor_pkg::out_t    result,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [16:0]  cfg_data
);
    import ccor_pkg::*;

    typedef struct packed {
        logic signed [31:0] x, y, z, u;
        logic signed [31:0] p1, omx, den1, m1, den2, zq, o1, den3, yc, my;
        logic [31:0]        mabs5;
        logic               mneg;
        logic               flt;
    } s1_t;

    typedef struct packed {
        logic signed [31:0] y, u, omx, den1, den2, den3, zq, my;
        logic signed [31:0] a, r1, t0, o2, v;
        logic [28:0]        mq;
        logic               mneg;
        logic               flt;
    } s2_t;

    typedef struct packed {
        logic signed [31:0] y, my, den1, den2, den3, o2;
        logic signed [31:0] tn, r2, t1, mfrac, rb;
        logic               flt;
    } s3_t;

    typedef struct packed {
        logic signed [31:0] t1y, d4, cm, d3;
        logic               flt;
    } side_t;

    typedef struct packed {
        logic signed [31:0] d0, d1, d2, d3, d4;
        logic               flt;
    } join_t;

    cfg_t  cfg;
    logic  in_go;
    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    s3_t   s3_reg, s3_next;
    side_t side_reg [0:DIV_LAT-1];
    side_t side_next;
    join_t jn_reg, jn_next;
    out_t  result_reg, result_next;
    logic  v1_reg, v2_reg, v3_reg, vj_reg, done_reg;
    logic  sv_reg [0:DIV_LAT-1];
    logic  va, vb, vc;
    qres_t qa, qb, qc;

    ccor_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign busy  = 1'b0;
    assign in_go = start & ~busy;

    // stage 1: products with constants and the affine terms
    always_comb
    begin
        qres_t p1, omx, den1, m1, den2, zq, o1, den3, yc, my;
        logic [32:0] mabs;
        p1   = q_mul(Q_TEN, in_item.rbnp_level);
        omx  = q_sub(Q_ONE, in_item.apc_level);
        den1 = q_sub(Q_ONE_FOUR_C, in_item.apc_level);
        m1   = q_mul(Q_B4, in_item.cell_mass);
        den2 = q_add(Q_FOUR_C, in_item.apc_level);
        zq   = q_mul(Q_QUART, in_item.p27_level);
        o1   = q_mul(Q_ONE_C, in_item.oxygen_level);
        den3 = q_add(Q_ONE_C, in_item.oxygen_level);
        yc   = q_mul(Q_ONE_C, in_item.cyclin_level);
        my   = q_mul(Q_ONE_C, in_item.cell_mass);
        mabs = in_item.cell_mass[31] ? (33'd0 - {1'b1, in_item.cell_mass})
                                     : {1'b0, in_item.cell_mass};
        s1_next.x     = in_item.apc_level;
        s1_next.y     = in_item.cyclin_level;
        s1_next.z     = in_item.p27_level;
        s1_next.u     = in_item.rbnp_level;
        s1_next.p1    = p1.val;
        s1_next.omx   = omx.val;
        s1_next.den1  = den1.val;
        s1_next.m1    = m1.val;
        s1_next.den2  = den2.val;
        s1_next.zq    = zq.val;
        s1_next.o1    = o1.val;
        s1_next.den3  = den3.val;
        s1_next.yc    = yc.val;
        s1_next.my    = my.val;
        // m / 10 rounds to (|m| + 5) / 10
        s1_next.mabs5 = mabs[31:0] + 32'd5;
        s1_next.mneg  = in_item.cell_mass[31];
        s1_next.flt   = p1.flt | omx.flt | den1.flt | m1.flt | den2.flt | zq.flt
                      | o1.flt | den3.flt | yc.flt | my.flt;
    end

    // stage 2
    always_comb
    begin
        qres_t a, r1, t0, o2, v;
        logic [63:0] prod;
        a    = q_add(Q_ONE, s1_reg.p1);
        r1   = q_mul(s1_reg.m1, s1_reg.x);
        t0   = q_add({15'b0, cfg.cyclin_decay_rate}, s1_reg.x);
        o2   = q_mul(s1_reg.o1, s1_reg.z);
        v    = q_add(Q_TENTH, s1_reg.yc);
        prod = s1_reg.mabs5 * RECIP_TEN;
        s2_next.y    = s1_reg.y;
        s2_next.u    = s1_reg.u;
        s2_next.omx  = s1_reg.omx;
        s2_next.den1 = s1_reg.den1;
        s2_next.den2 = s1_reg.den2;
        s2_next.den3 = s1_reg.den3;
        s2_next.zq   = s1_reg.zq;
        s2_next.my   = s1_reg.my;
        s2_next.a    = a.val;
        s2_next.r1   = r1.val;
        s2_next.t0   = t0.val;
        s2_next.o2   = o2.val;
        s2_next.v    = v.val;
        s2_next.mq   = prod[63:35];
        s2_next.mneg = s1_reg.mneg;
        s2_next.flt  = s1_reg.flt | a.flt | r1.flt | t0.flt | o2.flt | v.flt;
    end

    // stage 3
    always_comb
    begin
        qres_t tn, r2, t1, mfrac, rb;
        logic signed [31:0] md;
        md    = s2_reg.mneg ? (32'sd0 - {3'b0, s2_reg.mq}) : {3'b0, s2_reg.mq};
        tn    = q_mul(s2_reg.a, s2_reg.omx);
        r2    = q_mul(s2_reg.r1, s2_reg.y);
        t1    = q_add(s2_reg.t0, s2_reg.zq);
        mfrac = q_sub(Q_ONE, md);
        rb    = q_mul(s2_reg.v, s2_reg.u);
        s3_next.y     = s2_reg.y;
        s3_next.my    = s2_reg.my;
        s3_next.den1  = s2_reg.den1;
        s3_next.den2  = s2_reg.den2;
        s3_next.den3  = s2_reg.den3;
        s3_next.o2    = s2_reg.o2;
        s3_next.tn    = tn.val;
        s3_next.r2    = r2.val;
        s3_next.t1    = t1.val;
        s3_next.mfrac = mfrac.val;
        s3_next.rb    = rb.val;
        s3_next.flt   = s2_reg.flt | tn.flt | r2.flt | t1.flt | mfrac.flt | rb.flt;
    end

    // stage 4, head of the side line that runs beside the dividers
    always_comb
    begin
        qres_t t1y, d4, cm, d3;
        t1y = q_mul(s3_reg.t1, s3_reg.y);
        d4  = q_sub(Q_ONE_C, s3_reg.rb);
        cm  = q_mul({15'b0, cfg.p27_production_rate}, s3_reg.mfrac);
        d3  = q_mul(s3_reg.my, s3_reg.mfrac);
        side_next.t1y = t1y.val;
        side_next.d4  = d4.val;
        side_next.cm  = cm.val;
        side_next.d3  = d3.val;
        // the scaled production term only exists in the normal equation
        side_next.flt = s3_reg.flt | t1y.flt | d4.flt | d3.flt
                      | (cm.flt & ~cfg.cancer_mode);
    end

    ccor_div u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (s3_reg.tn),
        .den       (s3_reg.den1),
        .out_valid (va),
        .quo       (qa)
    );

    ccor_div u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (s3_reg.r2),
        .den       (s3_reg.den2),
        .out_valid (vb),
        .quo       (qb)
    );

    ccor_div u_div_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (s3_reg.o2),
        .den       (s3_reg.den3),
        .out_valid (vc),
        .quo       (qc)
    );

    // join of the quotients with the side line
    always_comb
    begin
        side_t sd;
        qres_t d0, d1, d2;
        sd = side_reg[DIV_LAT-1];
        d0 = q_sub(qa.val, qb.val);
        d1 = q_sub(Q_FOUR_C, sd.t1y);
        if (cfg.cancer_mode)
            d2 = q_sub({15'b0, cfg.p27_production_rate}, qc.val);
        else
            d2 = q_sub(sd.cm, qc.val);
        jn_next.d0  = d0.val;
        jn_next.d1  = d1.val;
        jn_next.d2  = d2.val;
        jn_next.d3  = sd.d3;
        jn_next.d4  = sd.d4;
        jn_next.flt = sd.flt | qa.flt | qb.flt | qc.flt | d0.flt | d1.flt | d2.flt;
    end

    // per-hour scaling
    always_comb
    begin
        qres_t r0, r1, r2, r3, r4;
        r0 = q_mul(Q_SIXTY, jn_reg.d0);
        r1 = q_mul(Q_SIXTY, jn_reg.d1);
        r2 = q_mul(Q_SIXTY, jn_reg.d2);
        r3 = q_mul(Q_SIXTY, jn_reg.d3);
        r4 = q_mul(Q_SIXTY, jn_reg.d4);
        result_next.apc_rate    = r0.val;
        result_next.cyclin_rate = r1.val;
        result_next.p27_rate    = r2.val;
        result_next.mass_rate   = r3.val;
        result_next.rbnp_rate   = r4.val;
        result_next.range_fault = jn_reg.flt | r0.flt | r1.flt | r2.flt | r3.flt | r4.flt;
    end

    always_ff @(posedge clk)
    begin
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        s3_reg      <= s3_next;
        side_reg[0] <= side_next;
        jn_reg      <= jn_next;
        result_reg  <= result_next;
    end

    for (genvar k = 1; k < DIV_LAT; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_reg[k-1];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[k] <= 1'b0;
            else
                sv_reg[k] <= sv_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            sv_reg[0] <= 1'b0;
            vj_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_go;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            sv_reg[0] <= v3_reg;
            // the divider valids line up with the side line by construction
            vj_reg    <= sv_reg[DIV_LAT-1] & va & vb & vc;
            done_reg  <= vj_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// File: tb/cell_cycle_ode_rhs_top_test.sv
// testbench for cell_cycle_ode_rhs_top: directed table then random state vectors
// predicts each result in Q16.16 and compares field by field; depends on ccor_pkg
`timescale 1ns / 1ps
module cell_cycle_ode_rhs_top_test;
    import ccor_pkg::*;

    localparam int LATENCY = 31;
    localparam int N_RANDOM = 450;
    localparam longint CYCLE_LIMIT = 200000;

    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t in_item;
    logic done;
    out_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [16:0] cfg_data;

    cell_cycle_ode_rhs_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // predictor copy of the registers
    logic mode_cancer;
    longint rate_a1;
    longint rate_c1;
    bit saturated;

    out_t rates_due[$];
    int errors = 0;
    longint cycles = 0;

    function automatic longint clamp32(longint v);
        if (v > MAX32)
        begin
            saturated = 1;
            return MAX32;
        end
        if (v < MIN32)
        begin
            saturated = 1;
            return MIN32;
        end
        return v;
    endfunction

    function automatic longint fx_add(longint a, longint b);
        return clamp32(a + b);
    endfunction

    function automatic longint fx_sub(longint a, longint b);
        return clamp32(a - b);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return clamp32((a * b + 32768) >>> 16);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        longint na;
        longint nb;
        longint q;
        if (b == 0)
        begin
            saturated = 1;
            return 0;
        end
        na = a < 0 ? -a : a;
        nb = b < 0 ? -b : b;
        q = ((na <<< 16) + nb / 2) / nb;
        return clamp32(((a < 0) != (b < 0)) ? -q : q);
    endfunction

    function automatic out_t ode_rates(in_t s);
        longint x, y, z, m, u, o, t, r, mfrac;
        longint d[5];
        out_t res;
        x = s.apc_level;
        y = s.cyclin_level;
        z = s.p27_level;
        m = s.cell_mass;
        u = s.rbnp_level;
        o = s.oxygen_level;
        saturated = 0;
        t = fx_mul(fx_add(Q_ONE, fx_mul(Q_TEN, u)), fx_sub(Q_ONE, x));
        t = fx_div(t, fx_sub(fx_add(Q_FOUR_C, Q_ONE), x));
        r = fx_mul(fx_mul(fx_mul(Q_B4, m), x), y);
        r = fx_div(r, fx_add(Q_FOUR_C, x));
        d[0] = fx_sub(t, r);
        t = fx_add(fx_add(rate_a1, fx_mul(Q_ONE, x)), fx_mul(Q_QUART, z));
        d[1] = fx_sub(Q_FOUR_C, fx_mul(t, y));
        r = fx_div(fx_mul(fx_mul(Q_ONE_C, o), z), fx_add(Q_ONE_C, o));
        mfrac = fx_sub(Q_ONE, fx_div(m, Q_TEN));
        if (mode_cancer)
            d[2] = fx_sub(rate_c1, r);
        else
            d[2] = fx_sub(fx_mul(rate_c1, mfrac), r);
        d[3] = fx_mul(fx_mul(Q_ONE_C, m), mfrac);
        t = fx_add(Q_TENTH, fx_mul(Q_ONE_C, y));
        d[4] = fx_sub(Q_ONE_C, fx_mul(t, u));
        res.apc_rate = 32'(fx_mul(Q_SIXTY, d[0]));
        res.cyclin_rate = 32'(fx_mul(Q_SIXTY, d[1]));
        res.p27_rate = 32'(fx_mul(Q_SIXTY, d[2]));
        res.mass_rate = 32'(fx_mul(Q_SIXTY, d[3]));
        res.rbnp_rate = 32'(fx_mul(Q_SIXTY, d[4]));
        res.range_fault = saturated;
        return res;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && done)
        begin
            if (rates_due.size() == 0)
            begin
                $error("result with nothing pending");
                errors++;
            end
            else
            begin
                want = rates_due.pop_front();
                if (result.apc_rate !== want.apc_rate)
                begin
                    $error("apc_rate expected %0d got %0d", want.apc_rate, result.apc_rate);
                    errors++;
                end
                if (result.cyclin_rate !== want.cyclin_rate)
                begin
                    $error("cyclin_rate expected %0d got %0d", want.cyclin_rate,
                           result.cyclin_rate);
                    errors++;
                end
                if (result.p27_rate !== want.p27_rate)
                begin
                    $error("p27_rate expected %0d got %0d", want.p27_rate, result.p27_rate);
                    errors++;
                end
                if (result.mass_rate !== want.mass_rate)
                begin
                    $error("mass_rate expected %0d got %0d", want.mass_rate, result.mass_rate);
                    errors++;
                end
                if (result.rbnp_rate !== want.rbnp_rate)
                begin
                    $error("rbnp_rate expected %0d got %0d", want.rbnp_rate, result.rbnp_rate);
                    errors++;
                end
                if (result.range_fault !== want.range_fault)
                begin
                    $error("range_fault expected %0b got %0b", want.range_fault,
                           result.range_fault);
                    errors++;
                end
            end
        end
    end

    // valid drops after each write so back to back writes stay apart
    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE: mode_cancer = val[0];
            CFG_A1: rate_a1 = val;
            CFG_C1: rate_c1 = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (rates_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // one transfer on the input channel; with typed set, typed_res carries a hand-typed result
    // start stays high after the transfer until a gap or settle drops it
    task automatic send_state(in_t s, bit typed, out_t typed_res);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        in_item <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rates_due.insert(rates_due.size(), typed ? typed_res : ode_rates(s));
    endtask

    function automatic logic signed [31:0] rand_level();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7FFFFFFF;
            2: return 32'sh80000000;
            3: return $signed($urandom_range(0, 32'h00140000)) - 32'sh00020000;
            default: return $urandom_range(0, 32'h0000C000);
        endcase
    endfunction

    typedef struct {
        in_t state_in;
        bit typed;
        out_t res;
    } vec_row_t;

    vec_row_t stim_table[$];

    initial
    begin
        in_t s;
        out_t none;
        vec_row_t row;
        logic [16:0] a1_set[4];
        logic [16:0] c1_set[4];
        none = '0;
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = '0;
        mode_cancer = 1'b0;
        rate_a1 = 3277;
        rate_c1 = 6554;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero state at reset defaults
        s = '0;
        row.state_in = s;
        row.typed = 0;
        row.res = none;
        stim_table.insert(stim_table.size(), row);
        s = '{default: 32'sh7FFFFFFF};
        row.state_in = s;
        stim_table.insert(stim_table.size(), row);
        s = '{default: 32'sh80000000};
        row.state_in = s;
        stim_table.insert(stim_table.size(), row);
        s = '{default: 32'sh00010000};
        row.state_in = s;
        stim_table.insert(stim_table.size(), row);
        // apc divisor 1.04 - x is zero
        s = '0;
        s.apc_level = Q_ONE_FOUR_C;
        row.state_in = s;
        stim_table.insert(stim_table.size(), row);
        // apc divisor 0.04 + x is zero
        s.apc_level = -Q_FOUR_C;
        row.state_in = s;
        stim_table.insert(stim_table.size(), row);
        // oxygen divisor 0.01 + o is zero
        s = '0;
        s.oxygen_level = -Q_ONE_C;
        s.p27_level = Q_ONE;
        row.state_in = s;
        stim_table.insert(stim_table.size(), row);
        s = '{32'sh00008000, 32'sh00004000, 32'sh00020000, 32'sh000A0000,
              32'sh00001000, 32'sh00010000};
        row.state_in = s;
        stim_table.insert(stim_table.size(), row);
        s = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
              32'sh80000000, 32'sh7FFFFFFF};
        row.state_in = s;
        stim_table.insert(stim_table.size(), row);
        s = '{32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA,
              32'sh55555555, 32'shAAAAAAAA};
        row.state_in = s;
        stim_table.insert(stim_table.size(), row);
        s = '{32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 32'sh55555555,
              32'shAAAAAAAA, 32'sh55555555};
        row.state_in = s;
        stim_table.insert(stim_table.size(), row);

        foreach (stim_table[i])
            send_state(stim_table[i].state_in, stim_table[i].typed, stim_table[i].res);
        settle();

        // cancer mode on the same table
        write_reg(CFG_MODE, 17'd1);
        foreach (stim_table[i])
            send_state(stim_table[i].state_in, 0, none);
        settle();

        a1_set = '{17'd0, 17'd65536, 17'h1FFFF, 17'd3277};
        c1_set = '{17'd65536, 17'd0, 17'h1FFFF, 17'd6554};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_A1, ph == 3 ? 17'($urandom_range(0, 65536)) : a1_set[ph]);
            write_reg(CFG_C1, ph == 3 ? 17'($urandom_range(0, 65536)) : c1_set[ph]);
            write_reg(CFG_MODE, 17'(ph % 2));
            for (int k = 0; k < N_RANDOM / 4; k++)
            begin
                s.apc_level = rand_level();
                s.cyclin_level = rand_level();
                s.p27_level = rand_level();
                s.cell_mass = rand_level();
                s.rbnp_level = rand_level();
                s.oxygen_level = rand_level();
                send_state(s, 0, none);
            end
            settle();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
